// ===== rtl/core/cpa_pkg.sv =====
package cpa_pkg;

   localparam int PAGE_BYTES = 4096;
   localparam int PAGE_COUNT = 256;
   localparam int OWNER_BITS = 8;

   localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
   localparam int IDX_W      = $clog2(PAGE_COUNT);
   localparam int CNT_W      = IDX_W + 1;
   localparam int ADDR_W     = 20;
   localparam int BYTES_W    = 21;
   localparam int STATUS_W   = 2;
   localparam int STRAT_W    = 2;
   localparam int PAGES_W    = BYTES_W - PAGE_SHIFT + 1;

   localparam logic CMD_ALLOC   = 1'b0;
   localparam logic CMD_RELEASE = 1'b1;

   localparam logic [STRAT_W-1:0] FIT_FIRST = 2'd0;
   localparam logic [STRAT_W-1:0] FIT_BEST  = 2'd1;
   localparam logic [STRAT_W-1:0] FIT_WORST = 2'd2;

   localparam logic [STATUS_W-1:0] ST_DONE      = 2'd0;
   localparam logic [STATUS_W-1:0] ST_NO_FIT    = 2'd1;
   localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;

   typedef struct packed {
      logic                  command;
      logic [OWNER_BITS-1:0] owner_id;
      logic [BYTES_W-1:0]    request_bytes;
      logic [STRAT_W-1:0]    strategy;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [ADDR_W-1:0]   start_address;
      logic [BYTES_W-1:0]  byte_count;
   } rsp_type;

   typedef struct packed {
      logic load;
      logic scan;
      logic mark;
   } ctl_cmd_type;

   typedef struct packed {
      logic bad;
      logic release_op;
      logic scan_done;
      logic mark_last;
   } ctl_status_type;

endpackage

// ===== rtl/core/contiguous_page_allocator_unit.sv =====
// Sequence: the accept cycle loads the request and a check state follows; an allocation
//   then scans every page and marks each granted page before the response, and a release
//   scans and frees matching pages, then responds; refused requests and owner zero releases skip the scan.
// Throughput: one transfer at a time; busy stays high until the response cycle ends.
// The result shows for one cycle on rsp_strobe; the receiver cannot stall.
// Reset (synchronous, active high) returns to idle and marks every page free at once.
module contiguous_page_allocator_unit (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  cpa_pkg::req_type req_data,
   output logic             rsp_strobe,
   output cpa_pkg::rsp_type rsp_data
);

   cpa_pkg::ctl_cmd_type    cmd;
   cpa_pkg::ctl_status_type st;

   cpa_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .st         (st),
      .cmd        (cmd),
      .busy       (busy),
      .rsp_strobe (rsp_strobe)
   );

   cpa_dp u_dp (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .cmd      (cmd),
      .st       (st),
      .rsp_data (rsp_data)
   );

endmodule

// ===== rtl/core/cpa_ctrl.sv =====
module cpa_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  cpa_pkg::ctl_status_type st,
   output cpa_pkg::ctl_cmd_type    cmd,
   output logic                    busy,
   output logic                    rsp_strobe
);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_CHECK = 3'd1;
   localparam logic [2:0] S_SCAN  = 3'd2;
   localparam logic [2:0] S_MARK  = 3'd3;
   localparam logic [2:0] S_RESP  = 3'd4;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            state_in = st.bad ? S_RESP : S_SCAN;
         end
         S_SCAN: begin
            cmd.scan = 1'b1;
            if (st.scan_done) begin
               state_in = st.release_op ? S_RESP : S_MARK;
            end
         end
         S_MARK: begin
            cmd.mark = 1'b1;
            if (st.mark_last) begin
               state_in = S_RESP;
            end
         end
         S_RESP: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy       = (state_ff != S_IDLE);
   assign rsp_strobe = (state_ff == S_RESP);

endmodule

// ===== rtl/core/cpa_dp.sv =====
module cpa_dp (
   input  logic                    clock,
   input  logic                    reset,
   input  cpa_pkg::req_type        req_data,
   input  cpa_pkg::ctl_cmd_type    cmd,
   output cpa_pkg::ctl_status_type st,
   output cpa_pkg::rsp_type        rsp_data
);

   localparam int PC  = cpa_pkg::PAGE_COUNT;
   localparam int IW  = cpa_pkg::IDX_W;
   localparam int CW  = cpa_pkg::CNT_W;
   localparam int OW  = cpa_pkg::OWNER_BITS;
   localparam int BW  = cpa_pkg::BYTES_W;
   localparam int AW  = cpa_pkg::ADDR_W;
   localparam int PW  = cpa_pkg::PAGES_W;
   localparam int SH  = cpa_pkg::PAGE_SHIFT;

   logic [OW-1:0] mem [PC];
   logic [PC-1:0] valid_ff;
   logic [OW-1:0] rd_data_ff;
   logic          rd_valid_ff;

   logic                         op_ff, op_in;
   logic [OW-1:0]                owner_ff, owner_in;
   logic [cpa_pkg::STRAT_W-1:0]  strat_ff, strat_in;
   logic [CW-1:0]                pages_ff, pages_in;
   logic                         bad_ff, bad_in;
   logic [CW-1:0]                rd_cnt_ff, rd_cnt_in;
   logic                         proc_vld_ff, proc_vld_in;
   logic [CW-1:0]                proc_idx_ff, proc_idx_in;
   logic [IW-1:0]                run_start_ff, run_start_in;
   logic [CW-1:0]                run_len_ff, run_len_in;
   logic [IW-1:0]                best_start_ff, best_start_in;
   logic [CW-1:0]                best_len_ff, best_len_in;
   logic                         found_ff, found_in;
   logic [CW-1:0]                freed_ff, freed_in;
   logic [CW-1:0]                mark_cnt_ff, mark_cnt_in;

   logic [BW:0]   round_sum;
   logic [PW-1:0] pages_full;
   logic          rd_issue;
   logic [OW-1:0] page_owner;
   logic          in_range;
   logic          page_free;
   logic          qualify;
   logic          better;
   logic          wr_en;
   logic [IW-1:0] wr_addr;
   logic [OW-1:0] wr_data;

   assign round_sum  = {1'b0, req_data.request_bytes} + (BW + 1)'(cpa_pkg::PAGE_BYTES - 1);
   assign rd_issue   = cmd.scan && (rd_cnt_ff <= CW'(PC));
   assign page_owner = rd_valid_ff ? rd_data_ff : '0;
   assign in_range   = (proc_idx_ff != CW'(PC));
   assign page_free  = in_range && (page_owner == '0);
   assign qualify    = (run_len_ff != '0) && (run_len_ff >= pages_ff);

   always_comb begin
      pages_full = round_sum[BW:SH];
      if (pages_full == '0) begin
         pages_full = PW'(1);
      end
   end

   always_comb begin
      case (strat_ff)
         cpa_pkg::FIT_FIRST: better = !found_ff;
         cpa_pkg::FIT_BEST:  better = !found_ff || (run_len_ff < best_len_ff);
         cpa_pkg::FIT_WORST: better = !found_ff || (run_len_ff > best_len_ff);
         default:            better = 1'b0;
      endcase
   end

   always_comb begin
      op_in         = op_ff;
      owner_in      = owner_ff;
      strat_in      = strat_ff;
      pages_in      = pages_ff;
      bad_in        = bad_ff;
      rd_cnt_in     = rd_cnt_ff;
      proc_vld_in   = rd_issue;
      proc_idx_in   = rd_cnt_ff;
      run_start_in  = run_start_ff;
      run_len_in    = run_len_ff;
      best_start_in = best_start_ff;
      best_len_in   = best_len_ff;
      found_in      = found_ff;
      freed_in      = freed_ff;
      mark_cnt_in   = mark_cnt_ff;
      wr_en         = 1'b0;
      wr_addr       = proc_idx_ff[IW-1:0];
      wr_data       = '0;

      if (rd_issue) begin
         rd_cnt_in = rd_cnt_ff + CW'(1);
      end

      if (proc_vld_ff) begin
         if (op_ff == cpa_pkg::CMD_RELEASE) begin
            if (in_range && (page_owner == owner_ff)) begin
               wr_en    = 1'b1;
               freed_in = freed_ff + CW'(1);
            end
         end else if (page_free) begin
            if (run_len_ff == '0) begin
               run_start_in = proc_idx_ff[IW-1:0];
            end
            run_len_in = run_len_ff + CW'(1);
         end else begin
            if (qualify && better) begin
               found_in      = 1'b1;
               best_start_in = run_start_ff;
               best_len_in   = run_len_ff;
            end
            run_len_in = '0;
         end
      end

      if (cmd.mark && found_ff) begin
         wr_en       = 1'b1;
         wr_addr     = best_start_ff + mark_cnt_ff[IW-1:0];
         wr_data     = owner_ff;
         mark_cnt_in = mark_cnt_ff + CW'(1);
      end

      if (cmd.load) begin
         op_in         = req_data.command;
         owner_in      = req_data.owner_id;
         strat_in      = req_data.strategy;
         pages_in      = pages_full[CW-1:0];
         if (req_data.command == cpa_pkg::CMD_RELEASE) begin
            bad_in = (req_data.owner_id == '0);
         end else begin
            bad_in = (req_data.owner_id == '0) || (req_data.strategy > cpa_pkg::FIT_WORST)
                     || (pages_full > PW'(PC));
         end
         rd_cnt_in     = '0;
         proc_vld_in   = 1'b0;
         run_len_in    = '0;
         best_start_in = '0;
         best_len_in   = '0;
         found_in      = 1'b0;
         freed_in      = '0;
         mark_cnt_in   = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff  <= mem[rd_cnt_ff[IW-1:0]];
      rd_valid_ff <= valid_ff[rd_cnt_ff[IW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr_en) begin
         valid_ff[wr_addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         proc_vld_ff <= 1'b0;
         found_ff    <= 1'b0;
         bad_ff      <= 1'b0;
         op_ff       <= cpa_pkg::CMD_ALLOC;
      end else begin
         proc_vld_ff <= proc_vld_in;
         found_ff    <= found_in;
         bad_ff      <= bad_in;
         op_ff       <= op_in;
      end
   end

   always_ff @(posedge clock) begin
      owner_ff      <= owner_in;
      strat_ff      <= strat_in;
      pages_ff      <= pages_in;
      rd_cnt_ff     <= rd_cnt_in;
      proc_idx_ff   <= proc_idx_in;
      run_start_ff  <= run_start_in;
      run_len_ff    <= run_len_in;
      best_start_ff <= best_start_in;
      best_len_ff   <= best_len_in;
      freed_ff      <= freed_in;
      mark_cnt_ff   <= mark_cnt_in;
   end

   assign st.bad        = bad_ff;
   assign st.release_op = (op_ff == cpa_pkg::CMD_RELEASE);
   assign st.scan_done  = proc_vld_ff && (proc_idx_ff == CW'(PC));
   assign st.mark_last  = !found_ff || (mark_cnt_ff == (pages_ff - CW'(1)));

   always_comb begin
      rsp_data = '0;
      if (op_ff == cpa_pkg::CMD_RELEASE) begin
         if (bad_ff || (freed_ff == '0)) begin
            rsp_data.status = cpa_pkg::ST_NOT_FOUND;
         end else begin
            rsp_data.status     = cpa_pkg::ST_DONE;
            rsp_data.byte_count = BW'({freed_ff, {SH{1'b0}}});
         end
      end else begin
         if (bad_ff || !found_ff) begin
            rsp_data.status = cpa_pkg::ST_NO_FIT;
         end else begin
            rsp_data.status        = cpa_pkg::ST_DONE;
            rsp_data.start_address = AW'({best_start_ff, {SH{1'b0}}});
            rsp_data.byte_count    = BW'({pages_ff, {SH{1'b0}}});
         end
      end
   end

endmodule

// ===== rtl/core/cpa_chk.sv =====
module cpa_chk (
   input logic             clock,
   input logic             reset,
   input logic             start,
   input logic             busy,
   input cpa_pkg::req_type req_data,
   input logic             rsp_strobe,
   input cpa_pkg::rsp_type rsp_data
);

   a_strobe_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> busy)
      else $error("response outside a transfer");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted transfer did not raise busy");

   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> (!busy && !rsp_strobe))
      else $error("no return to idle after response");

   a_not_found_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && (rsp_data.status == cpa_pkg::ST_NOT_FOUND))
      |-> ((rsp_data.byte_count == '0) && (rsp_data.start_address == '0)))
      else $error("empty release reports bytes");

   a_no_fit_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && (rsp_data.status == cpa_pkg::ST_NO_FIT))
      |-> ((rsp_data.byte_count == '0) && (rsp_data.start_address == '0)))
      else $error("failed allocation reports bytes");

endmodule

bind contiguous_page_allocator_unit cpa_chk u_cpa_chk (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .req_data   (req_data),
   .rsp_strobe (rsp_strobe),
   .rsp_data   (rsp_data)
);
